// ===== src/rtn_pkg.sv =====
`default_nettype none

package rtn_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS     = 16;
    localparam int COORD_W       = 32;
    localparam int VEC_W         = COORD_W + 1;
    localparam int MIN_W         = 17;
    localparam int WGT_W         = 18;
    localparam int IDX_W         = 16;
    localparam int CNT_W         = 17;
    localparam int MAX_TRIANGLES = 65536;

    // Shared multiplier: operands are split into limbs of LIMB_W bits.
    localparam int MUL_W      = 35;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LIMB_W     = 34;
    localparam int MINOR_W    = 2 * LIMB_W;
    localparam int STEP_W     = 4;
    localparam int STEP_COUNT = 12;

    // Determinants stay below 2^99 in magnitude; numerators carry FRAC_BITS more.
    localparam int DET_W = 104;
    localparam int NUM_W = DET_W + FRAC_BITS;

    // Quotient magnitude bits; the top bit flags a quotient out of any valid range.
    localparam int QUO_W = 34;
    localparam int MAG_W = QUO_W - 1;
    localparam int CMP_W = QUO_W + 1;

    localparam logic signed [CMP_W-1:0] FIX_ONE = CMP_W'(1 << FRAC_BITS);

    typedef logic signed [VEC_W-1:0] t_elem;
    typedef t_elem [2:0] t_vec3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_det_sts;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/rtn_in_if.sv =====
`default_nettype none

interface rtn_in_if import rtn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      last;

    modport source (output valid, kind, ax, ay, az, bx, by, bz, cx, cy, cz, last,
                    input ready);
    modport sink (input valid, kind, ax, ay, az, bx, by, bz, cx, cy, cz, last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/rtn_out_if.sv =====
`default_nettype none

interface rtn_out_if import rtn_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [COORD_W-1:0] distance;
    logic signed [WGT_W-1:0]   beta;
    logic signed [WGT_W-1:0]   gamma;
    logic [IDX_W-1:0]          triangle_index;

    modport source (output valid, hit, distance, beta, gamma, triangle_index,
                    input ready);
    modport sink (input valid, hit, distance, beta, gamma, triangle_index,
                  output ready);
endinterface

`default_nettype wire

// ===== src/rtn_cfg_if.sv =====
`default_nettype none

interface rtn_cfg_if import rtn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MIN_W-1:0] min_distance;

    modport source (output valid, min_distance, input ready);
    modport sink (input valid, min_distance, output ready);
endinterface

`default_nettype wire

// ===== src/rtn_det_unit.sv =====
`default_nettype none

module rtn_det_unit import rtn_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_vec3                    i_p,
    input  wire t_vec3                    i_q,
    input  wire t_vec3                    i_s,
    output t_det_sts                      o_sts,
    output logic signed [DET_W-1:0]       o_det
);

    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(STEP_COUNT - 1);
    localparam logic [STEP_W-1:0] STEP_ACC   = STEP_W'(STEP_COUNT / 2);

    logic                      r_busy;
    logic                      r_pv;
    logic                      r_done;
    logic [STEP_W-1:0]         r_step;
    logic [STEP_W-1:0]         r_pstep;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MINOR_W-1:0] r_m [3];
    logic signed [DET_W-1:0]   r_acc;

    logic signed [MUL_W-1:0]   op_a;
    logic signed [MUL_W-1:0]   op_b;
    logic signed [PROD_W-1:0]  prod;
    logic [STEP_W-1:0]         iss_k;
    logic [STEP_W-1:0]         con_k;
    logic [1:0]                iss_j;
    logic [1:0]                con_j;
    logic signed [DET_W-1:0]   term;

    // Row and column of the two products that form 2x2 minor j.
    function automatic logic [1:0] minor_row(input logic [1:0] j);
        return (j == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic logic [1:0] minor_col(input logic [1:0] j);
        return (j == 2'd2) ? 2'd1 : 2'd2;
    endfunction

    // Operand selection: six minor products, then each row element times both minor limbs.
    always_comb begin
        iss_k = r_step - STEP_ACC;
        iss_j = 2'd0;
        op_a  = '0;
        op_b  = '0;
        if (r_step < STEP_ACC) begin
            iss_j = r_step[2:1];
            if (!r_step[0]) begin
                op_a = MUL_W'(i_q[minor_row(iss_j)]);
                op_b = MUL_W'(i_s[minor_col(iss_j)]);
            end else begin
                op_a = MUL_W'(i_q[minor_col(iss_j)]);
                op_b = MUL_W'(i_s[minor_row(iss_j)]);
            end
        end else begin
            iss_j = iss_k[2:1];
            op_a  = MUL_W'(i_p[iss_j]);
            if (iss_k[0]) begin
                op_b = $signed({1'b0, r_m[iss_j][LIMB_W-1:0]});
            end else begin
                op_b = MUL_W'($signed(r_m[iss_j][MINOR_W-1:LIMB_W]));
            end
        end
    end

    assign prod  = op_a * op_b;
    assign con_k = r_pstep - STEP_ACC;
    assign con_j = (r_pstep < STEP_ACC) ? r_pstep[2:1] : con_k[2:1];
    assign term  = con_k[0] ? DET_W'(r_prod) : (DET_W'(r_prod) <<< LIMB_W);

    // Control: issue twelve products, then flag the result once the last one is summed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pv   <= r_busy;
            r_done <= r_pv && (r_pstep == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_LAST)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: product register, minors and the determinant accumulator.
    always_ff @(posedge i_clk) begin
        r_prod  <= prod;
        r_pstep <= r_step;
        if (i_start) begin
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
        end
        if (i_start) begin
            r_acc <= '0;
        end else if (r_pv) begin
            if (r_pstep < STEP_ACC) begin
                if (r_pstep[0]) begin
                    r_m[con_j] <= r_m[con_j] - MINOR_W'(r_prod);
                end else begin
                    r_m[con_j] <= MINOR_W'(r_prod);
                end
            end else if (con_j == 2'd1) begin
                r_acc <= r_acc - term;
            end else begin
                r_acc <= r_acc + term;
            end
        end
    end

    assign o_sts.busy = r_busy || r_pv;
    assign o_sts.done = r_done;
    assign o_det      = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_pv)
        else $error("determinant start while busy");
    a_done_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("determinant done while still issuing");
    a_pipe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_pv)
        else $error("issued product not captured");

endmodule

`default_nettype wire

// ===== src/rtn_divider.sv =====
`default_nettype none

module rtn_divider import rtn_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DET_W-1:0] i_den,
    output t_div_rsp              o_rsp
);

    localparam int DIV_W = DET_W + QUO_W - 1;
    localparam int CNT_B = $clog2(QUO_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_B-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [QUO_W-1:0] r_quo;
    logic             ge;

    // One restoring step per cycle, divisor shifted right each time.
    assign ge = DIV_W'(r_rem) >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_B'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_B'(1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_div <= {i_den, (QUO_W - 1)'(0)};
            r_cnt <= CNT_B'(QUO_W);
            r_quo <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[QUO_W-2:0], ge};
            if (ge) begin
                r_rem <= r_rem - NUM_W'(r_div);
            end
            r_div <= r_div >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_quo[QUO_W-1];
    assign o_rsp.quo  = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divide start while busy");
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider running with empty count");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");

endmodule

`default_nettype wire

// ===== src/ray_triangle_nearest_hit.sv =====
`default_nettype none

// Nearest ray/triangle hit search in Q16.16 fixed point.
// Requests on i_in are either a ray (kind 0: origin, direction, distance limit),
// which restarts the search, or a triangle (kind 1: vertices A, B, C). A triangle
// with last set produces one result request on o_out: hit flag, nearest distance,
// barycentric weights and the triangle's position since the ray request or the last result.
// i_cfg writes the minimum hit distance; the user must write it only while the block is
// idle, which the block itself does not enforce; i_cfg is always ready. For a triangle,
// from acceptance until i_in.ready returns, the block computes four 3x3 determinants
// (twelve products each on one shared 35x35 multiplier, then pipeline drain and handoff),
// three 34-step restoring divisions on one shared divider, and a check and count step.
// A zero system determinant ends the triangle without the divisions or the check. With
// last set, the result enters the output register once that register is free.
// i_in.ready is high only while no triangle is in work. A finished result sits in
// the output register until taken; a new request is accepted meanwhile, but a second
// result waits inside the block until the first is taken.
// Reset (synchronous, active low) clears the ray to zero, the minimum distance to 7
// and the best hit to none.
module ray_triangle_nearest_hit import rtn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtn_in_if.sink     i_in,
    rtn_out_if.source  o_out,
    rtn_cfg_if.sink    i_cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DET   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]                r_state;
    logic [MIN_W-1:0]          r_min;
    logic signed [COORD_W-1:0] r_org [3];
    logic signed [COORD_W-1:0] r_dir [3];
    logic signed [COORD_W-1:0] r_limit;
    t_vec3                     r_ab;
    t_vec3                     r_ac;
    t_vec3                     r_rh;
    logic [1:0]                r_phase;
    logic                      r_last;
    logic                      r_det_go;
    logic                      r_div_go;
    logic                      r_det_neg;
    logic                      r_num_neg;
    logic                      r_rej;
    logic [DET_W-1:0]          r_den_mag;
    logic signed [CMP_W-1:0]   r_beta_q;
    logic signed [CMP_W-1:0]   r_gamma_q;
    logic signed [CMP_W-1:0]   r_t_q;

    logic signed [COORD_W-1:0] r_best_dist;
    logic signed [WGT_W-1:0]   r_best_beta;
    logic signed [WGT_W-1:0]   r_best_gamma;
    logic [IDX_W-1:0]          r_best_idx;
    logic                      r_found;
    logic [CNT_W-1:0]          r_count;

    logic                      r_out_valid;
    logic                      r_o_hit;
    logic signed [COORD_W-1:0] r_o_dist;
    logic signed [WGT_W-1:0]   r_o_beta;
    logic signed [WGT_W-1:0]   r_o_gamma;
    logic [IDX_W-1:0]          r_o_idx;

    logic signed [COORD_W-1:0] in_a [3];
    logic signed [COORD_W-1:0] in_b [3];
    logic signed [COORD_W-1:0] in_c [3];
    t_vec3                     dir_v;
    t_vec3                     sel_p;
    t_vec3                     sel_q;
    t_vec3                     sel_s;
    logic                      in_acc;
    logic                      emit_go;
    t_det_sts                  det_sts;
    logic signed [DET_W-1:0]   det_val;
    logic [DET_W-1:0]          det_abs;
    t_div_rsp                  div_rsp;
    logic signed [CMP_W-1:0]   q_pos;
    logic signed [CMP_W-1:0]   q_sig;
    logic                      reject;
    logic                      closer;

    // Input field arrays.
    assign in_a[0] = i_in.ax;
    assign in_a[1] = i_in.ay;
    assign in_a[2] = i_in.az;
    assign in_b[0] = i_in.bx;
    assign in_b[1] = i_in.by;
    assign in_b[2] = i_in.bz;
    assign in_c[0] = i_in.cx;
    assign in_c[1] = i_in.cy;
    assign in_c[2] = i_in.cz;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign emit_go     = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    // Determinant columns: phase 0 is the system matrix, phases 1 to 3 swap in A - e.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dir_v[k] = VEC_W'(r_dir[k]);
        end
        sel_p = (r_phase == 2'd1) ? r_rh : r_ab;
        sel_q = (r_phase == 2'd2) ? r_rh : r_ac;
        sel_s = (r_phase == 2'd3) ? r_rh : dir_v;
    end

    rtn_det_unit u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_det_go),
        .i_p     (sel_p),
        .i_q     (sel_q),
        .i_s     (sel_s),
        .o_sts   (det_sts),
        .o_det   (det_val)
    );

    assign det_abs = det_val[DET_W-1] ? DET_W'(-det_val) : DET_W'(det_val);

    rtn_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   ({det_abs, FRAC_BITS'(0)}),
        .i_den   (r_den_mag),
        .o_rsp   (div_rsp)
    );

    // Signed quotient, truncated toward zero.
    assign q_pos = $signed(CMP_W'(div_rsp.quo[MAG_W-1:0]));
    assign q_sig = (r_num_neg ^ r_det_neg) ? -q_pos : q_pos;

    // Range tests on t, gamma and beta, then the strict nearest test.
    assign reject = r_rej
        || (r_t_q < $signed(CMP_W'(r_min)))
        || (r_t_q > CMP_W'(r_limit))
        || r_gamma_q[CMP_W-1] || (r_gamma_q > FIX_ONE)
        || r_beta_q[CMP_W-1] || (r_beta_q > (FIX_ONE - r_gamma_q));
    assign closer = r_t_q < CMP_W'(r_best_dist);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_W'(7);
        end else if (i_cfg.valid) begin
            r_min <= i_cfg.min_distance;
        end
    end

    // Sequencer, ray and best-hit state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_det_go     <= 1'b0;
            r_div_go     <= 1'b0;
            r_limit      <= '0;
            r_best_dist  <= '0;
            r_best_beta  <= '1;
            r_best_gamma <= '1;
            r_best_idx   <= '0;
            r_found      <= 1'b0;
            r_count      <= '0;
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else begin
            r_det_go <= 1'b0;
            r_div_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_in.kind) begin
                        for (int k = 0; k < 3; k++) begin
                            r_org[k] <= in_a[k];
                            r_dir[k] <= in_b[k];
                        end
                        r_limit      <= i_in.cx;
                        r_best_dist  <= i_in.cx;
                        r_best_beta  <= '1;
                        r_best_gamma <= '1;
                        r_best_idx   <= '0;
                        r_found      <= 1'b0;
                        r_count      <= '0;
                    end else if (in_acc) begin
                        if (r_count < CNT_W'(MAX_TRIANGLES)) begin
                            r_det_go <= 1'b1;
                            r_state  <= S_DET;
                        end else if (i_in.last) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DET: begin
                    if (det_sts.done) begin
                        if (r_phase != 2'd0) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end else if (det_val == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_det_go <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_phase == 2'd3) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_det_go <= 1'b1;
                            r_state  <= S_DET;
                        end
                    end
                end
                S_CHECK: begin
                    if (!reject && closer) begin
                        r_found      <= 1'b1;
                        r_best_dist  <= r_t_q[COORD_W-1:0];
                        r_best_beta  <= r_beta_q[WGT_W-1:0];
                        r_best_gamma <= r_gamma_q[WGT_W-1:0];
                        r_best_idx   <= r_count[IDX_W-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_best_dist  <= r_limit;
                        r_best_beta  <= '1;
                        r_best_gamma <= '1;
                        r_best_idx   <= '0;
                        r_found      <= 1'b0;
                        r_count      <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-triangle working registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.kind) begin
            r_last  <= i_in.last;
            r_phase <= 2'd0;
            r_rej   <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_ab[k] <= VEC_W'(in_a[k]) - VEC_W'(in_b[k]);
                r_ac[k] <= VEC_W'(in_a[k]) - VEC_W'(in_c[k]);
                r_rh[k] <= VEC_W'(in_a[k]) - VEC_W'(r_org[k]);
            end
        end
        if (r_state == S_DET && det_sts.done) begin
            if (r_phase == 2'd0) begin
                r_det_neg <= det_val[DET_W-1];
                r_den_mag <= det_abs;
                r_phase   <= 2'd1;
            end else begin
                r_num_neg <= det_val[DET_W-1];
            end
        end
        if (r_state == S_DIV && div_rsp.done) begin
            r_rej <= r_rej || div_rsp.ovf;
            case (r_phase)
                2'd1:    r_beta_q  <= q_sig;
                2'd2:    r_gamma_q <= q_sig;
                default: r_t_q     <= q_sig;
            endcase
            if (r_phase != 2'd3) begin
                r_phase <= r_phase + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_o_hit   <= r_found;
            r_o_dist  <= r_best_dist;
            r_o_beta  <= r_best_beta;
            r_o_gamma <= r_best_gamma;
            r_o_idx   <= r_best_idx;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.hit            = r_o_hit;
    assign o_out.distance       = r_o_dist;
    assign o_out.beta           = r_o_beta;
    assign o_out.gamma          = r_o_gamma;
    assign o_out.triangle_index = r_o_idx;

    a_hit_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> !r_best_beta[WGT_W-1] && !r_best_gamma[WGT_W-1])
        else $error("recorded hit with negative weight");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TRIANGLES))
        else $error("triangle count beyond bound");
    a_no_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> r_best_idx == '0)
        else $error("index set without a hit");
    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !det_sts.busy)
        else $error("ready while determinant unit busy");

endmodule

`default_nettype wire

// ===== sim/tb_ray_triangle_nearest_hit.sv =====
module tb_ray_triangle_nearest_hit;
    import rtn_pkg::*;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    localparam logic KIND_RAY      = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;
    localparam int   UNIT          = 1 << FRAC_BITS;
    localparam int   CYCLE_LIMIT   = 4000000;
    localparam int   SETTLE_CYCLES = 250;
    localparam int   RANDOM_ITEMS  = 1620;
    localparam int   HOLD_SPACING  = 500;

    typedef struct {
        logic   kind;
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
        logic   last;
    } ray_req_t;

    typedef struct {
        logic                    hit;
        coord_t                  distance;
        logic signed [WGT_W-1:0] beta;
        logic signed [WGT_W-1:0] gamma;
        logic [IDX_W-1:0]        index;
    } hit_rsp_t;

    // Nearest-hit predictor and queue of expected hit reports.
    class hit_scoreboard;
        logic [MIN_W-1:0]        min_dist;
        wide_t                   origin[3];
        wide_t                   dir[3];
        coord_t                  limit;
        coord_t                  best_dist;
        logic signed [WGT_W-1:0] best_beta;
        logic signed [WGT_W-1:0] best_gamma;
        logic [IDX_W-1:0]        best_index;
        logic                    found;
        int unsigned             tri_count;
        hit_rsp_t                pending_hits[$];
        int                      errors;

        function new();
            min_dist = 7;
            for (int k = 0; k < 3; k++) begin
                origin[k] = 0;
                dir[k] = 0;
            end
            limit = 0;
            errors = 0;
            restart_search();
        endfunction

        function void restart_search();
            best_dist = limit;
            best_beta = -1;
            best_gamma = -1;
            best_index = 0;
            found = 0;
            tri_count = 0;
        endfunction

        // Determinant of the 3x3 matrix whose columns are p, q and s.
        function wide_t det3(input wide_t p[3], input wide_t q[3], input wide_t s[3]);
            wide_t m0, m1, m2;
            m0 = q[1] * s[2] - q[2] * s[1];
            m1 = q[0] * s[2] - q[2] * s[0];
            m2 = q[0] * s[1] - q[1] * s[0];
            return p[0] * m0 - p[1] * m1 + p[2] * m2;
        endfunction

        function void test_triangle(input ray_req_t r);
            wide_t ab[3], ac[3], rh[3];
            wide_t det, one, t, beta, gamma;
            for (int k = 0; k < 3; k++) begin
                ab[k] = wide_t'(r.a[k]) - wide_t'(r.b[k]);
                ac[k] = wide_t'(r.a[k]) - wide_t'(r.c[k]);
                rh[k] = wide_t'(r.a[k]) - origin[k];
            end
            det = det3(ab, ac, dir);
            if (det == 0) return;
            one = wide_t'(UNIT);
            beta = (det3(rh, ac, dir) * one) / det;
            gamma = (det3(ab, rh, dir) * one) / det;
            t = (det3(ab, ac, rh) * one) / det;
            if (t < wide_t'({1'b0, min_dist}) || t > wide_t'(limit)) return;
            if (gamma < 0 || gamma > one) return;
            if (beta < 0 || beta > one - gamma) return;
            // Only a strictly nearer hit replaces the current best.
            if (t < wide_t'(best_dist)) begin
                found = 1;
                best_dist = t[COORD_W-1:0];
                best_beta = beta[WGT_W-1:0];
                best_gamma = gamma[WGT_W-1:0];
                best_index = tri_count[IDX_W-1:0];
            end
        endfunction

        function void note_request(input ray_req_t r);
            hit_rsp_t e;
            if (r.kind == KIND_RAY) begin
                for (int k = 0; k < 3; k++) begin
                    origin[k] = wide_t'(r.a[k]);
                    dir[k] = wide_t'(r.b[k]);
                end
                limit = r.c[0];
                restart_search();
                return;
            end
            if (tri_count < MAX_TRIANGLES) begin
                test_triangle(r);
                tri_count++;
            end
            if (r.last) begin
                e.hit = found;
                e.distance = best_dist;
                e.beta = best_beta;
                e.gamma = best_gamma;
                e.index = best_index;
                pending_hits.push_back(e);
                restart_search();
            end
        endfunction

        function void check_result(input hit_rsp_t got);
            hit_rsp_t e;
            if (pending_hits.size() == 0) begin
                $error("unexpected hit report: hit=%0b distance=%0d", got.hit, got.distance);
                errors++;
                return;
            end
            e = pending_hits.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit: expected %0b, got %0b", e.hit, got.hit);
                errors++;
            end
            if (got.distance !== e.distance) begin
                $error("distance: expected %0d, got %0d", e.distance, got.distance);
                errors++;
            end
            if (got.beta !== e.beta) begin
                $error("beta: expected %0d, got %0d", e.beta, got.beta);
                errors++;
            end
            if (got.gamma !== e.gamma) begin
                $error("gamma: expected %0d, got %0d", e.gamma, got.gamma);
                errors++;
            end
            if (got.index !== e.index) begin
                $error("triangle_index: expected %0d, got %0d", e.index, got.index);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    rtn_in_if  in_if();
    rtn_out_if out_if();
    rtn_cfg_if cfg_if();

    hit_scoreboard sb = new();

    int  cycle_count = 0;
    bit  no_idle = 0;
    bit  hold_request = 0;
    int  stall_left = 0;

    ray_triangle_nearest_hit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // Clock.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Watch accepted requests on the input and configuration ports.
    always @(posedge i_clk) begin
        ray_req_t r;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            r.kind = in_if.kind;
            r.a = '{in_if.ax, in_if.ay, in_if.az};
            r.b = '{in_if.bx, in_if.by, in_if.bz};
            r.c = '{in_if.cx, in_if.cy, in_if.cz};
            r.last = in_if.last;
            sb.note_request(r);
        end
        if (i_rst_n && cfg_if.valid && cfg_if.ready) sb.min_dist = cfg_if.min_distance;
    end

    // Check each accepted hit report.
    always @(posedge i_clk) begin
        hit_rsp_t got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.hit = out_if.hit;
            got.distance = out_if.distance;
            got.beta = out_if.beta;
            got.gamma = out_if.gamma;
            got.index = out_if.triangle_index;
            sb.check_result(got);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 0;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 2);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic ray_req_t mk(input logic kind, input int ax, input int ay, input int az,
                                    input int bx, input int by, input int bz,
                                    input int cx, input int cy, input int cz,
                                    input logic last);
        ray_req_t r;
        r.kind = kind;
        r.a = '{ax, ay, az};
        r.b = '{bx, by, bz};
        r.c = '{cx, cy, cz};
        r.last = last;
        return r;
    endfunction

    task automatic send(input ray_req_t r);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= r.kind;
        {in_if.ax, in_if.ay, in_if.az} <= {r.a[0], r.a[1], r.a[2]};
        {in_if.bx, in_if.by, in_if.bz} <= {r.b[0], r.b[1], r.b[2]};
        {in_if.cx, in_if.cy, in_if.cz} <= {r.c[0], r.c[1], r.c[2]};
        in_if.last <= r.last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every hit report has come back and the block is idle.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_distance(input logic [MIN_W-1:0] value);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.min_distance <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic int rand_full();
        return int'($urandom());
    endfunction

    // A ray heading roughly along +z from near the axis.
    function automatic ray_req_t rand_ray();
        int lim;
        lim = ($urandom_range(0, 9) == 0) ? rand_full() : $urandom_range(1, 40) * UNIT;
        return mk(KIND_RAY, $urandom_range(0, 4 * UNIT) - 2 * UNIT,
                  $urandom_range(0, 4 * UNIT) - 2 * UNIT, -$urandom_range(0, 4 * UNIT),
                  $urandom_range(0, UNIT / 2) - UNIT / 4, $urandom_range(0, UNIT / 2) - UNIT / 4,
                  $urandom_range(UNIT, 2 * UNIT), lim, $urandom(), $urandom(), $urandom_range(0, 1));
    endfunction

    // A triangle spread across the ray path at a random depth, or pure noise.
    function automatic ray_req_t rand_triangle(input logic last);
        int z;
        if ($urandom_range(0, 9) == 0)
            return mk(KIND_TRIANGLE, rand_full(), rand_full(), rand_full(), rand_full(),
                      rand_full(), rand_full(), rand_full(), rand_full(), rand_full(), last);
        z = $urandom_range(0, 30 * UNIT);
        return mk(KIND_TRIANGLE,
                  $urandom_range(0, 8 * UNIT) - 4 * UNIT, $urandom_range(0, 8 * UNIT) - 4 * UNIT,
                  z + $urandom_range(0, UNIT) - UNIT / 2,
                  $urandom_range(0, 8 * UNIT) - 4 * UNIT, $urandom_range(0, 8 * UNIT) - 4 * UNIT,
                  z + $urandom_range(0, UNIT) - UNIT / 2,
                  $urandom_range(0, 8 * UNIT) - 4 * UNIT, $urandom_range(0, 8 * UNIT) - 4 * UNIT,
                  z + $urandom_range(0, UNIT) - UNIT / 2, last);
    endfunction

    initial begin
        int sent;
        int n;
        int next_hold;
        ray_req_t r;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.kind <= KIND_RAY;
        {in_if.ax, in_if.ay, in_if.az, in_if.bx, in_if.by, in_if.bz} <= '0;
        {in_if.cx, in_if.cy, in_if.cz} <= '0;
        in_if.last <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.min_distance <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Triangle before any ray: zero determinant, report of no hit.
        send(mk(KIND_TRIANGLE, UNIT, 2 * UNIT, 3, -UNIT, 5, 7, 9, -9, UNIT, 1'b1));
        // Ray along +z with limit 5.0; its last mark is ignored.
        send(mk(KIND_RAY, 0, 0, 0, 0, 0, UNIT, 5 * UNIT, 0, 0, 1'b1));
        // Hit exactly at the limit is not recorded.
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 5 * UNIT, 3 * UNIT, -UNIT, 5 * UNIT,
                -UNIT, 3 * UNIT, 5 * UNIT, 1'b1));
        // Hit below the minimum distance, then a hit at 2.0 and its duplicate.
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 0, 3 * UNIT, -UNIT, 0, -UNIT, 3 * UNIT, 0, 1'b0));
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 2 * UNIT, 3 * UNIT, -UNIT, 2 * UNIT,
                -UNIT, 3 * UNIT, 2 * UNIT, 1'b0));
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 2 * UNIT, 3 * UNIT, -UNIT, 2 * UNIT,
                -UNIT, 3 * UNIT, 2 * UNIT, 1'b0));
        // Degenerate triangle, then a nearer one hit on its edge.
        send(mk(KIND_TRIANGLE, 0, 0, UNIT, 0, 0, UNIT, 0, 0, UNIT, 1'b0));
        send(mk(KIND_TRIANGLE, 0, 0, UNIT, UNIT, 0, UNIT, 0, UNIT, UNIT, 1'b1));
        // Extreme coordinates.
        send(mk(KIND_RAY, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0));
        send(mk(KIND_TRIANGLE, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0));
        send(mk(KIND_TRIANGLE, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 1'b1));
        send(mk(KIND_RAY, 0, 0, -UNIT, 0, 0, UNIT, 32'h80000000, 0, 0, 1'b0));
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 2 * UNIT, 3 * UNIT, -UNIT, 2 * UNIT,
                -UNIT, 3 * UNIT, 2 * UNIT, 1'b1));

        // Minimum distance of zero and of 1.0, with hits at and just below the minimum.
        write_min_distance('0);
        send(mk(KIND_RAY, 0, 0, 0, 0, 0, UNIT, 20 * UNIT, 0, 0, 1'b0));
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, 0, 3 * UNIT, -UNIT, 0, -UNIT, 3 * UNIT, 0, 1'b1));
        write_min_distance(17'h10000);
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, UNIT, 3 * UNIT, -UNIT, UNIT,
                -UNIT, 3 * UNIT, UNIT, 1'b0));
        send(mk(KIND_TRIANGLE, -UNIT, -UNIT, UNIT - 1, 3 * UNIT, -UNIT, UNIT - 1,
                -UNIT, 3 * UNIT, UNIT - 1, 1'b1));
        write_min_distance(7);

        // Random searches: usually a ray, then a few triangles ending on a last mark.
        sent = 0;
        next_hold = HOLD_SPACING;
        while (sent < RANDOM_ITEMS) begin
            if (sent > 0 && sent % 400 < 8) begin
                write_min_distance(($urandom_range(0, 1) == 0) ? $urandom_range(0, 17'h10000)
                                                               : $urandom_range(0, 64));
            end
            no_idle = (sent % 600) > 450;
            // Long receiver hold-off each time the item count passes the next mark.
            if (sent >= next_hold) begin
                hold_request = 1;
                next_hold = next_hold + HOLD_SPACING;
            end
            if ($urandom_range(0, 5) != 0) begin
                send(rand_ray());
                sent++;
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            for (int k = 0; k < n; k++) begin
                r = rand_triangle(k == n - 1 ? 1'b1 : ($urandom_range(0, 15) == 0));
                send(r);
                sent++;
            end
        end
        no_idle = 0;
        drain();

        if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
